>>> rtl/bale_pkg.sv
// Shared types, codes and helpers for the bounded array list engine.
package bale_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int SEC_W    = $clog2(CAPACITY);
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  // What every cell does on this cycle.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_WR,
    CMD_SWAP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [POS_W-1:0]  pos;
    logic [SEC_W-1:0]  sec;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] data_p;
    logic [DATA_W-1:0] data_q;
  } cell_cmd_t;

  function automatic logic is_neg(input logic [DATA_W-1:0] v);
    return v[DATA_W-1];
  endfunction

  function automatic logic is_pos(input logic [DATA_W-1:0] v);
    return (v != '0) && !v[DATA_W-1];
  endfunction

endpackage

>>> rtl/bale_cell.sv
// One list slot: holds an entry and takes from its neighbors on shifts.
module bale_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  bale_pkg::cell_cmd_t           cmd,
  input  logic [bale_pkg::DATA_W-1:0]   left_data,
  input  logic [bale_pkg::DATA_W-1:0]   right_data,
  output logic [bale_pkg::DATA_W-1:0]   data
);
  import bale_pkg::*;

  localparam logic [31:0] MY_IDX = 32'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [31:0]       pos_w;
  logic [31:0]       sec_w;

  assign pos_w = 32'(cmd.pos);
  assign sec_w = 32'(cmd.sec);
  assign data  = data_r;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.kind)
      CMD_INS: begin
        if (MY_IDX == pos_w) begin
          data_nxt = cmd.value;
        end else if (MY_IDX > pos_w) begin
          data_nxt = left_data;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= pos_w) begin
          data_nxt = right_data;
        end
      end
      CMD_WR: begin
        if (MY_IDX == pos_w) begin
          data_nxt = cmd.value;
        end
      end
      CMD_SWAP: begin
        if (MY_IDX == pos_w) begin
          data_nxt = cmd.data_q;
        end else if (MY_IDX == sec_w) begin
          data_nxt = cmd.data_p;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> rtl/bounded_array_list_engine.sv
// Bounded array list engine: top level with the cell row and list bookkeeping.
// Holds an ordered list of up to CAPACITY signed 32-bit entries in a row of
// cells, one entry per cell. Each request is one operation (insert, delete,
// read, replace, swap) and yields one result with status, data, count and a
// flag that is high when positive entries outnumber negative ones. On an
// accepted request, every cell shifts or rewrites in parallel from its
// neighbors, and the result lands in an output register. A new request is
// taken each cycle the output register is empty or being drained. Entries
// above the count are never read and carry no reset.
module bounded_array_list_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bale_pkg::OP_W-1:0]     in_operation,
  input  logic [bale_pkg::POS_W-1:0]    in_position,
  input  logic [bale_pkg::SEC_W-1:0]    in_second_position,
  input  logic signed [bale_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bale_pkg::STAT_W-1:0]   out_status,
  output logic signed [bale_pkg::DATA_W-1:0] out_data,
  output logic [bale_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_more_positive
);
  import bale_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [DATA_W-1:0] cell_data [CAPACITY];
  cell_cmd_t         cmd;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_tot_r, pos_tot_nxt;
  logic [CNT_W-1:0]  neg_tot_r, neg_tot_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic              more_pos_r;

  logic              fire;
  logic [CW-1:0]     p_ext, q_ext, cnt_ext;
  logic [IDX_W-1:0]  p_idx, q_idx;
  logic [DATA_W-1:0] data_p, data_q;
  logic [DATA_W-1:0] val_u;
  cmd_kind_t         kind;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  assign p_ext   = CW'(in_position);
  assign q_ext   = CW'(in_second_position);
  assign cnt_ext = CW'(count_r);
  assign p_idx   = IDX_W'(p_ext);
  assign q_idx   = IDX_W'(q_ext);
  assign data_p  = cell_data[p_idx];
  assign data_q  = cell_data[q_idx];
  assign val_u   = in_value;

  always_comb begin
    status_nxt  = ST_OK;
    data_nxt    = '0;
    kind        = CMD_HOLD;
    count_nxt   = count_r;
    pos_tot_nxt = pos_tot_r;
    neg_tot_nxt = neg_tot_r;
    unique case (in_operation)
      OP_INSERT: begin
        if (p_ext > cnt_ext) begin
          status_nxt = ST_BADPOS;
        end else if (count_r == CAP_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          kind        = CMD_INS;
          data_nxt    = val_u;
          count_nxt   = count_r + 1'b1;
          pos_tot_nxt = pos_tot_r + CNT_W'(is_pos(val_u));
          neg_tot_nxt = neg_tot_r + CNT_W'(is_neg(val_u));
        end
      end
      OP_DELETE, OP_READ, OP_REPLACE, OP_SWAP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (p_ext >= cnt_ext ||
                     (in_operation == OP_SWAP && q_ext >= cnt_ext)) begin
          status_nxt = ST_BADPOS;
        end else begin
          unique case (in_operation)
            OP_DELETE: begin
              kind        = CMD_DEL;
              data_nxt    = data_p;
              count_nxt   = count_r - 1'b1;
              pos_tot_nxt = pos_tot_r - CNT_W'(is_pos(data_p));
              neg_tot_nxt = neg_tot_r - CNT_W'(is_neg(data_p));
            end
            OP_READ: begin
              data_nxt = data_p;
            end
            OP_REPLACE: begin
              kind        = CMD_WR;
              data_nxt    = val_u;
              pos_tot_nxt = pos_tot_r - CNT_W'(is_pos(data_p)) + CNT_W'(is_pos(val_u));
              neg_tot_nxt = neg_tot_r - CNT_W'(is_neg(data_p)) + CNT_W'(is_neg(val_u));
            end
            default: begin
              kind = CMD_SWAP;
            end
          endcase
        end
      end
      default: status_nxt = ST_BADPOS;
    endcase
  end

  // Cells only move on an accepted request.
  always_comb begin
    cmd.kind   = fire ? kind : CMD_HOLD;
    cmd.pos    = in_position;
    cmd.sec    = in_second_position;
    cmd.value  = val_u;
    cmd.data_p = data_p;
    cmd.data_q = data_q;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (k == 0) begin : g_first
      assign left_d = cell_data[k];
    end else begin : g_left
      assign left_d = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[k];
    end else begin : g_right
      assign right_d = cell_data[k+1];
    end
    bale_cell #(
      .IDX(k)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pos_tot_r   <= '0;
      neg_tot_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      count_r     <= count_nxt;
      pos_tot_r   <= pos_tot_nxt;
      neg_tot_r   <= neg_tot_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r    <= status_nxt;
      data_r      <= data_nxt;
      out_count_r <= COUNT_W'(count_nxt);
      more_pos_r  <= (pos_tot_nxt > neg_tot_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_data          = data_r;
  assign out_count         = out_count_r;
  assign out_more_positive = more_pos_r;

endmodule
